// File: src/gfi_pkg.sv
// Shared types, constants and helpers for the GF(2^8) inverse block.
package gfi_pkg;

  localparam int unsigned ElemW = 8;
  localparam int unsigned PolyW = ElemW + 1;
  localparam int unsigned DegW  = 4;

  // x^8 + x^4 + x^3 + x + 1
  localparam logic [PolyW-1:0] GfPoly  = 9'h11B;
  localparam logic [ElemW-1:0] GfLow   = 8'h1B;
  localparam logic [PolyW-1:0] PolyOne = 9'h001;

  typedef logic [PolyW-1:0] poly_t;
  typedef logic [DegW-1:0]  deg_t;

  // Operands and results of one reduction step.
  typedef struct packed {
    poly_t u;
    poly_t v;
    poly_t g1;
    poly_t g2;
  } euclid_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  // Index of the highest set bit; zero for a zero word.
  function automatic deg_t poly_degree(poly_t p);
    deg_t d;
    d = '0;
    for (int k = 0; k < PolyW; k++) begin
      if (p[k]) begin
        d = deg_t'(k);
      end
    end
    return d;
  endfunction

endpackage

// File: src/gfi_step.sv
// One extended-Euclid step: cancel the leading term by shift and xor.
module gfi_step (
  input  gfi_pkg::euclid_t cur_i,
  output gfi_pkg::euclid_t nxt_o
);

  gfi_pkg::deg_t  du;
  gfi_pkg::deg_t  dv;
  gfi_pkg::deg_t  shamt;
  gfi_pkg::poly_t big;
  gfi_pkg::poly_t sml;
  gfi_pkg::poly_t gbig;
  gfi_pkg::poly_t gsml;

  always_comb begin
    du = gfi_pkg::poly_degree(cur_i.u);
    dv = gfi_pkg::poly_degree(cur_i.v);
    // keep the higher-degree remainder on the u side
    if (du < dv) begin
      big   = cur_i.v;
      sml   = cur_i.u;
      gbig  = cur_i.g2;
      gsml  = cur_i.g1;
      shamt = dv - du;
    end else begin
      big   = cur_i.u;
      sml   = cur_i.v;
      gbig  = cur_i.g1;
      gsml  = cur_i.g2;
      shamt = du - dv;
    end
    nxt_o.u  = big ^ (sml << shamt);
    nxt_o.v  = sml;
    nxt_o.g1 = gbig ^ (gsml << shamt);
    nxt_o.g2 = gsml;
  end

endmodule

// File: src/gf256_inverse.sv
// GF(2^8) inverse: sequencer around a shared shift-xor Euclid step.
// A beat loads the work register; the sequencer then applies Euclid steps until
// u is one (each step lowers deg(u)+deg(v) by at least one).
// Zero and one need no step. The block takes no new byte before the last
// result is registered: the input stalls while a byte is in work and
// while a finished result waits for the output register to free up.
// Reset (rst_ni, async, active low) clears the sequencer and output valid.
module gf256_inverse (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] inverse_o
);

  gfi_pkg::state_e  state_q, state_d;
  gfi_pkg::euclid_t work_q, work_d;
  gfi_pkg::euclid_t step_res;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       inverse_q, inverse_d;
  logic             in_beat;
  logic             finish;
  logic             out_free;

  gfi_step u_step (
    .cur_i (work_q),
    .nxt_o (step_res)
  );

  assign in_stall_o = (state_q != gfi_pkg::S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (work_q.u == gfi_pkg::PolyOne);

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    out_valid_d = out_valid_q && out_stall_i;
    inverse_d   = inverse_q;
    unique case (state_q)
      gfi_pkg::S_IDLE: begin
        if (in_beat) begin
          // zero has no inverse: start finished with a zero coefficient
          work_d.u  = (value_i == '0) ? gfi_pkg::PolyOne : {1'b0, value_i};
          work_d.v  = gfi_pkg::GfPoly;
          work_d.g1 = (value_i == '0) ? '0 : gfi_pkg::PolyOne;
          work_d.g2 = '0;
          state_d   = gfi_pkg::S_RUN;
        end
      end
      gfi_pkg::S_RUN: begin
        if (finish) begin
          if (out_free) begin
            inverse_d   = work_q.g1[8] ? (work_q.g1[7:0] ^ gfi_pkg::GfLow)
                                       : work_q.g1[7:0];
            out_valid_d = 1'b1;
            state_d     = gfi_pkg::S_IDLE;
          end
        end else begin
          work_d = step_res;
        end
      end
      default: begin
        state_d = gfi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    inverse_q <= inverse_d;
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the GF(2^8) inverse block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned EuclidMaxSteps = 64;
  localparam int unsigned ItemsPerPhase  = 250;
  localparam int unsigned ShowMax        = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] inverse_o;

  logic [7:0] inverse_q[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  gf256_inverse i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .inverse_o  (inverse_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Index of the highest set bit, -1 for zero.
  function automatic int top_bit(input logic [31:0] p);
    int d;
    d = -1;
    for (int k = 0; k < 32; k++) begin
      if (p[k]) begin
        d = k;
      end
    end
    return d;
  endfunction

  // Extended Euclid over binary polynomials, then reduce the coefficient.
  function automatic logic [7:0] inverse_of(input logic [7:0] a);
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] g1;
    logic [31:0] g2;
    logic [31:0] t;
    int j;
    int steps;
    int d;
    u = {24'h0, a};
    v = {23'h0, gfi_pkg::GfPoly};
    g1 = 32'h1;
    g2 = 32'h0;
    steps = 0;
    if (u == 32'h0) begin
      return 8'h00;
    end
    while (u != 32'h1 && steps < EuclidMaxSteps) begin
      j = top_bit(u) - top_bit(v);
      if (j < 0) begin
        t = u; u = v; v = t;
        t = g1; g1 = g2; g2 = t;
        j = -j;
      end
      if (j > 16) begin
        break;
      end
      u = u ^ (v << j);
      g1 = (g1 ^ (g2 << j)) & 32'h000F_FFFF;
      steps++;
    end
    d = top_bit(g1);
    while (d >= 8) begin
      g1 = g1 ^ ({23'h0, gfi_pkg::GfPoly} << (d - 8));
      d = top_bit(g1);
    end
    return g1[7:0];
  endfunction

  // Receiver stall, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker: each output beat against the oldest expected inverse.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ShowMax) begin
          $display("unexpected result beat: inverse %02h", inverse_o);
        end
      end else begin
        want = inverse_q.pop_front();
        if (inverse_o !== want) begin
          fail_count++;
          if (fail_count <= ShowMax) begin
            $display("inverse mismatch: expected %02h, got %02h", want, inverse_o);
          end
        end
      end
    end
  end

  // One input beat; valid stays high for a back-to-back successor.
  task automatic send_value(input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_i    = val;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    inverse_q.push_back(inverse_of(val));
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    in_valid_i = 1'b0;
    while (inverse_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic test_directed();
    logic [7:0] corner[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    corner = '{8'h00, 8'h01, 8'hFF, 8'h80, 8'h03, 8'h53, 8'hCA, 8'h8D,
               8'hFE, 8'h7F, 8'h55, 8'hAA, 8'h1B, 8'h00, 8'h01};
    for (int k = 1; k < 8; k++) begin
      corner.push_back(8'h01 << k);
    end
    foreach (corner[k]) begin
      send_value(corner[k]);
    end
    wait_results_done();
  endtask

  task automatic run_random(input int unsigned n_items);
    logic [7:0] val;
    for (int unsigned k = 0; k < n_items; k++) begin
      // now and then hold off until the block has drained
      if ($urandom_range(99) < 3) begin
        wait_results_done();
      end
      case ($urandom_range(15))
        0:       val = 8'h00;
        1:       val = 8'h01;
        default: val = 8'($urandom_range(255));
      endcase
      send_value(val);
    end
    wait_results_done();
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 12;
    recv_idle_pct = 50;
    run_random(ItemsPerPhase);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 50;
    recv_idle_pct = 12;
    run_random(ItemsPerPhase);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ItemsPerPhase);
  endtask

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = 8'h00;
    out_stall_i   = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    repeat (32) @(negedge clk_i);
    if (inverse_q.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gfi_pkg.sv
src/gfi_step.sv
src/gf256_inverse.sv
dv/testbench.sv
